>>> design/ecat_pkg.sv
// ----------------------------------------------------------------------------
// ecat_pkg: shared types and constants of the EtherCAT frame parser
// Parse phases, result kinds, EtherType codes and the packed result layout.
// ----------------------------------------------------------------------------
package ecat_pkg;

    typedef enum logic [14:0] {
        PH_START    = 15'b000000000000001,
        PH_ETH      = 15'b000000000000010,
        PH_SLL      = 15'b000000000000100,
        PH_RAW      = 15'b000000000001000,
        PH_NULL     = 15'b000000000010000,
        PH_VLAN     = 15'b000000000100000,
        PH_IP       = 15'b000000001000000,
        PH_IPV4     = 15'b000000010000000,
        PH_IPV6     = 15'b000000100000000,
        PH_UDP      = 15'b000001000000000,
        PH_ECAT_HDR = 15'b000010000000000,
        PH_DG_HDR   = 15'b000100000000000,
        PH_DG_DATA  = 15'b001000000000000,
        PH_DG_WKC   = 15'b010000000000000,
        PH_IDLE     = 15'b100000000000000
    } phase_t;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_RECORD  = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [2:0] LINK_ETH  = 3'd0;
    localparam logic [2:0] LINK_SLL  = 3'd1;
    localparam logic [2:0] LINK_RAW  = 3'd2;
    localparam logic [2:0] LINK_NULL = 3'd3;

    localparam logic [15:0] ET_VLAN = 16'h8100;
    localparam logic [15:0] ET_QINQ = 16'h88A8;
    localparam logic [15:0] ET_IPV4 = 16'h0800;
    localparam logic [15:0] ET_IPV6 = 16'h86DD;
    localparam logic [15:0] ET_ECAT = 16'h88A4;
    localparam logic [7:0]  PROTO_UDP = 8'h11;

    localparam logic [15:0] UDP_PORT_RESET = 16'd34980;

    typedef struct packed {
        logic [15:0] working_counter;
        logic [15:0] irq_bits;
        logic        circulating;
        logic        more_follows;
        logic [10:0] datagram_length;
        logic [15:0] addr_offset;
        logic [15:0] addr_position;
        logic [7:0]  datagram_index;
        logic [7:0]  command;
        logic [7:0]  payload_byte;
        logic [1:0]  kind;
    } result_t;

    localparam int RES_BITS = $bits(result_t);

endpackage

>>> design/ecat_core.sv
// ----------------------------------------------------------------------------
// ecat_core: byte-wise parse step
// Holds the frame state and, for each accepted byte, produces up to two
// results (a payload byte or datagram record, then a frame summary).
// ----------------------------------------------------------------------------
module ecat_core import ecat_pkg::*; #(
    parameter int POSITION_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  logic [7:0]    frame_byte,
    input  logic          last_byte,
    input  logic [2:0]    link_type,
    input  logic [15:0]   udp_port,
    output logic          res0_valid,
    output result_t       res0,
    output logic          res1_valid,
    output result_t       res1
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    phase_t                   phase_reg, phase_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [15:0]              etype_reg, etype_next;
    logic [15:0]              vlan_reg, vlan_next;
    logic [5:0]               ihe_reg, ihe_next;
    logic [POSITION_BITS-1:0] pend_reg, pend_next;
    logic [10:0]              rem_reg, rem_next;
    logic [14:0]              info_reg, info_next;
    logic [7:0]               hdr_reg [10];
    logic [7:0]               hdr_next [10];
    logic [10:0]              left_reg, left_next;
    logic [4:0]               flags_reg, flags_next;
    logic [15:0]              off_reg, off_next;
    logic [31:0]              gath_reg, gath_next;
    logic                     udp_reg, udp_next;

    phase_t      ph;
    logic [15:0] off;
    logic [15:0] et;
    logic        do_disp;
    logic        disp_vlan;
    logic        ip_do;
    logic [10:0] dlen;
    logic [15:0] lw;
    logic [11:0] need;
    logic [15:0] ulen;
    // Wide enough for the largest position plus the largest UDP length.
    logic [32:0] pend_sum;
    logic [31:0] fam;

    function automatic logic [15:0] h16(input logic [7:0] lo, input logic [7:0] hi);
        return {hi, lo};
    endfunction

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        etype_next = etype_reg;
        vlan_next  = vlan_reg;
        ihe_next   = ihe_reg;
        pend_next  = pend_reg;
        rem_next   = rem_reg;
        info_next  = info_reg;
        hdr_next   = hdr_reg;
        left_next  = left_reg;
        flags_next = flags_reg;
        gath_next  = gath_reg;
        udp_next   = udp_reg;
        off        = off_reg;
        off_next   = (off_reg != 16'hFFFF) ? off_reg + 16'd1 : off_reg;
        res0_valid = 1'b0;
        res0       = '0;
        res1_valid = 1'b0;
        res1       = '0;
        do_disp    = 1'b0;
        disp_vlan  = 1'b0;
        et         = '0;
        ip_do      = 1'b0;
        lw         = h16(hdr_reg[6], hdr_reg[7]);
        dlen       = lw[10:0];
        need       = 12'd12;
        ulen       = gath_reg[15:0];
        pend_sum   = '0;
        fam        = gath_reg | ({24'd0, frame_byte} << (off_reg[1:0] * 8));

        ph = phase_reg;
        if (ph == PH_START) begin
            unique case (link_type)
                LINK_ETH:  ph = PH_ETH;
                LINK_SLL:  ph = PH_SLL;
                LINK_RAW:  ph = PH_RAW;
                LINK_NULL: ph = PH_NULL;
                default:   ph = PH_IDLE;
            endcase
        end
        phase_next = ph;
        if ((ph == PH_ECAT_HDR || ph == PH_DG_HDR || ph == PH_DG_DATA ||
             ph == PH_DG_WKC) && pend_reg != POS_MAX && pos_reg >= pend_reg) begin
            ph = PH_IDLE;
            phase_next = PH_IDLE;
            off = '0;
            gath_next = '0;
            off_next = 16'd1;
        end

        unique case (ph)
            PH_ETH: begin
                if (off == 16'd12) gath_next = {24'd0, frame_byte};
                else if (off == 16'd13) begin
                    do_disp = 1'b1; disp_vlan = 1'b1; et = {gath_reg[7:0], frame_byte};
                end
            end
            PH_SLL: begin
                if (off == 16'd14) gath_next = {24'd0, frame_byte};
                else if (off == 16'd15) begin
                    do_disp = 1'b1; et = {gath_reg[7:0], frame_byte};
                end
            end
            PH_RAW: begin
                if (frame_byte[7:4] == 4'd4) etype_next = ET_IPV4;
                else if (frame_byte[7:4] == 4'd6) etype_next = ET_IPV6;
                ip_do = 1'b1;
            end
            PH_NULL: begin
                if (off < 16'd4) gath_next = fam;
                if (off == 16'd3) begin
                    off_next = '0; gath_next = '0;
                    if (fam == 32'd2 || fam == 32'h02000000) begin
                        etype_next = ET_IPV4; phase_next = PH_IP;
                    end else if (fam == 32'd30 || fam == 32'h1E000000 ||
                                 fam == 32'd24 || fam == 32'h18000000) begin
                        etype_next = ET_IPV6; phase_next = PH_IP;
                    end else phase_next = PH_IDLE;
                end
            end
            PH_VLAN: begin
                if (off < 16'd4) gath_next = {gath_reg[23:0], frame_byte};
                if (off == 16'd3) begin
                    vlan_next = gath_reg[23:8];
                    flags_next[2] = 1'b1;
                    do_disp = 1'b1; disp_vlan = 1'b1; et = {gath_reg[7:0], frame_byte};
                end
            end
            PH_IP: ip_do = 1'b1;
            PH_IPV4: begin
                if (off == 16'd9 && frame_byte != PROTO_UDP) begin
                    phase_next = PH_IDLE; off_next = '0; gath_next = '0;
                end else if (off + 16'd1 == {10'd0, ihe_reg}) begin
                    flags_next[4:3] = 2'd1;
                    phase_next = PH_UDP; off_next = '0; gath_next = '0;
                end
            end
            PH_IPV6: begin
                if (off == 16'd6 && frame_byte != PROTO_UDP) begin
                    phase_next = PH_IDLE; off_next = '0; gath_next = '0;
                end else if (off == 16'd39) begin
                    flags_next[4:3] = 2'd2;
                    phase_next = PH_UDP; off_next = '0; gath_next = '0;
                end
            end
            PH_UDP: begin
                if (off >= 16'd2 && off <= 16'd5)
                    gath_next = {gath_reg[23:0], frame_byte};
                if (off == 16'd7) begin
                    off_next = '0; gath_next = '0;
                    if (ulen < 16'd8 || gath_reg[31:16] != udp_port) phase_next = PH_IDLE;
                    else begin
                        pend_sum = 33'(pos_reg) + 33'd1 + 33'(ulen - 16'd8);
                        pend_next = (pend_sum > 33'(POS_MAX)) ? POS_MAX
                                    : pend_sum[POSITION_BITS-1:0];
                        udp_next = 1'b1;
                        phase_next = PH_ECAT_HDR;
                    end
                end
            end
            PH_ECAT_HDR: begin
                if (off == 16'd0) gath_next = {24'd0, frame_byte};
                else begin
                    if (udp_reg) flags_next[1:0] = 2'b11;
                    info_next = {frame_byte[7:4], frame_byte[2:0], gath_reg[7:0]};
                    rem_next = {frame_byte[2:0], gath_reg[7:0]};
                    off_next = '0; gath_next = '0;
                    phase_next = (rem_next >= 11'd12) ? PH_DG_HDR : PH_IDLE;
                end
            end
            PH_DG_HDR: begin
                if (off < 16'd10) hdr_next[off[3:0]] = frame_byte;
                if (off == 16'd9) begin
                    off_next = '0; gath_next = '0;
                    need = 12'd12 + {1'b0, dlen};
                    if (need > {1'b0, rem_reg}) phase_next = PH_IDLE;
                    else begin
                        left_next = dlen;
                        phase_next = (dlen != 11'd0) ? PH_DG_DATA : PH_DG_WKC;
                    end
                end
            end
            PH_DG_DATA: begin
                res0_valid = 1'b1;
                res0.kind = KIND_PAYLOAD;
                res0.payload_byte = frame_byte;
                left_next = left_reg - 11'd1;
                if (left_next == 11'd0) begin
                    phase_next = PH_DG_WKC; off_next = '0; gath_next = '0;
                end
            end
            PH_DG_WKC: begin
                if (off == 16'd0) gath_next = {24'd0, frame_byte};
                else begin
                    res0_valid = 1'b1;
                    res0.kind = KIND_RECORD;
                    res0.command = hdr_reg[0];
                    res0.datagram_index = hdr_reg[1];
                    res0.addr_position = h16(hdr_reg[2], hdr_reg[3]);
                    res0.addr_offset = h16(hdr_reg[4], hdr_reg[5]);
                    res0.datagram_length = dlen;
                    res0.more_follows = lw[15];
                    res0.circulating = lw[14];
                    res0.irq_bits = h16(hdr_reg[8], hdr_reg[9]);
                    res0.working_counter = {frame_byte, gath_reg[7:0]};
                    rem_next = rem_reg - 11'd12 - dlen;
                    off_next = '0; gath_next = '0;
                    phase_next = (rem_next >= 11'd12) ? PH_DG_HDR : PH_IDLE;
                end
            end
            default: ;
        endcase

        if (ip_do) begin
            off_next = '0; gath_next = '0;
            if (frame_byte[7:4] == 4'd4) begin
                if (frame_byte[3:0] < 4'd5) phase_next = PH_IDLE;
                else begin
                    ihe_next = {frame_byte[3:0], 2'b00};
                    phase_next = PH_IPV4; off_next = 16'd1;
                end
            end else if (frame_byte[7:4] == 4'd6) begin
                ihe_next = 6'd40;
                phase_next = PH_IPV6; off_next = 16'd1;
            end else phase_next = PH_IDLE;
        end

        if (do_disp) begin
            etype_next = et;
            off_next = '0; gath_next = '0;
            if (disp_vlan && (et == ET_VLAN || et == ET_QINQ)) phase_next = PH_VLAN;
            else if (et == ET_ECAT) begin
                flags_next[0] = 1'b1; udp_next = 1'b0; phase_next = PH_ECAT_HDR;
            end else if (et == ET_IPV4 || et == ET_IPV6) phase_next = PH_IP;
            else phase_next = PH_IDLE;
        end

        if (last_byte) begin
            res1_valid = 1'b1;
            res1.kind = KIND_SUMMARY;
            res1.command = {3'd0, flags_next};
            res1.datagram_index = {4'd0, info_next[14:11]};
            res1.addr_position = etype_next;
            res1.addr_offset = vlan_next;
            res1.datagram_length = info_next[10:0];
            phase_next = PH_START;
            pos_next = '0;
            etype_next = '0;
            vlan_next = '0;
            ihe_next = '0;
            pend_next = POS_MAX;
            rem_next = '0;
            info_next = '0;
            for (int i = 0; i < 10; i++) hdr_next[i] = '0;
            left_next = '0;
            flags_next = '0;
            off_next = '0;
            gath_next = '0;
            udp_next = 1'b0;
        end else begin
            pos_next = (pos_reg != POS_MAX) ? pos_reg + 1'b1 : pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            pos_reg   <= '0;
            etype_reg <= '0;
            vlan_reg  <= '0;
            ihe_reg   <= '0;
            pend_reg  <= POS_MAX;
            rem_reg   <= '0;
            info_reg  <= '0;
            for (int i = 0; i < 10; i++) hdr_reg[i] <= '0;
            left_reg  <= '0;
            flags_reg <= '0;
            off_reg   <= '0;
            gath_reg  <= '0;
            udp_reg   <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            etype_reg <= etype_next;
            vlan_reg  <= vlan_next;
            ihe_reg   <= ihe_next;
            pend_reg  <= pend_next;
            rem_reg   <= rem_next;
            info_reg  <= info_next;
            hdr_reg   <= hdr_next;
            left_reg  <= left_next;
            flags_reg <= flags_next;
            off_reg   <= off_next;
            gath_reg  <= gath_next;
            udp_reg   <= udp_next;
        end
    end

endmodule

>>> design/ecat_out.sv
// ----------------------------------------------------------------------------
// ecat_out: result register with two slots
// Holds the up to two results of one byte and hands them out in order.
// ----------------------------------------------------------------------------
module ecat_out import ecat_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  logic    in0_valid,
    input  result_t in0,
    input  logic    in1_valid,
    input  result_t in1,
    output logic    empty_after,
    output logic    m_valid,
    output result_t m_res,
    output logic    m_end,
    input  logic    m_ready
);

    logic    v0_reg, v1_reg;
    result_t r0_reg, r1_reg;
    logic    pop;

    assign pop = m_valid && m_ready;
    // The slots drain to empty when the head is taken and nothing is behind it.
    assign empty_after = !v0_reg || (pop && !v1_reg);
    assign m_valid = v0_reg;
    assign m_res   = r0_reg;
    assign m_end   = !v1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else if (load) begin
            v0_reg <= in0_valid || in1_valid;
            v1_reg <= in0_valid && in1_valid;
            r0_reg <= in0_valid ? in0 : in1;
            r1_reg <= in1;
        end else if (pop) begin
            v0_reg <= v1_reg;
            v1_reg <= 1'b0;
            r0_reg <= r1_reg;
        end
    end

endmodule

>>> design/ethercat_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// ethercat_frame_parser_unit: EtherCAT datagram parser for captured frames
// Top level: configuration registers, parse core and result register.
// ----------------------------------------------------------------------------
// One captured byte is taken per cycle while the result slots have room.
// Each byte is parsed in the cycle it is accepted and its results (at most
// two) land in a two-slot result register; a byte that yields one result
// leaves the slots free again as it is taken, so the stream runs at one byte
// per cycle while the consumer keeps up. A byte with two results (the final
// byte with a record or payload byte, plus the frame summary) stalls the input until both are taken.
module ethercat_frame_parser_unit import ecat_pkg::*; #(
    parameter int POSITION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // frame_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // payload_byte, command, datagram_index, addr_position, addr_offset,
    // datagram_length, more_follows, circulating, irq_bits, working_counter
    output logic [103:0] m_tdata,
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast    // run_end
);

    localparam logic CFG_LINK_TYPE = 1'b0;
    localparam logic CFG_UDP_PORT  = 1'b1;

    logic [2:0]  link_reg;
    logic [15:0] port_reg;
    logic        step, empty_after, v0, v1;
    result_t     r0, r1, mres;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg <= LINK_ETH;
            port_reg <= UDP_PORT_RESET;
        end else if (cfg_we) begin
            if (cfg_index == CFG_LINK_TYPE) link_reg <= cfg_data[2:0];
            if (cfg_index == CFG_UDP_PORT) port_reg <= cfg_data;
        end
    end

    assign s_tready = empty_after;
    assign step = s_tvalid && s_tready;

    ecat_core #(.POSITION_BITS(POSITION_BITS)) u_core (
        .aclk, .aresetn, .step,
        .frame_byte(s_tdata), .last_byte(s_tlast),
        .link_type(link_reg), .udp_port(port_reg),
        .res0_valid(v0), .res0(r0), .res1_valid(v1), .res1(r1)
    );

    ecat_out u_out (
        .aclk, .aresetn, .load(step),
        .in0_valid(v0), .in0(r0), .in1_valid(v1), .in1(r1),
        .empty_after, .m_valid(m_tvalid), .m_res(mres), .m_end(m_tlast),
        .m_ready(m_tready)
    );

    assign m_tuser = mres.kind;
    assign m_tdata = {3'b000, mres.working_counter, mres.irq_bits, mres.circulating,
                      mres.more_follows, mres.datagram_length, mres.addr_offset,
                      mres.addr_position, mres.datagram_index, mres.command,
                      mres.payload_byte};

endmodule
